// ===== sv/kinematic_car_euler_step_assert.svh =====
// Assertion macros for the kinematic car Euler step block.
// Used by kce_ctrl; relies on clk and rst_n in the including module.
`ifndef KINEMATIC_CAR_EULER_STEP_ASSERT_SVH
`define KINEMATIC_CAR_EULER_STEP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define KCE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define KCE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/kce_pkg.sv =====
// Shared types, constants and tables for the kinematic car Euler step block.
// No dependencies.
`timescale 1ns / 1ps

package kce_pkg;

    localparam int CORDIC_ITERS = 14;
    localparam int DIV_BITS     = 18;
    localparam int MUL_STEPS    = 13;

    localparam logic signed [32:0] CORDIC_GAIN  = 33'sd652032875;
    localparam logic signed [15:0] STEER_LIMIT  = 16'sd10430;
    localparam logic signed [17:0] QUARTER_TURN = 18'sd16384;
    localparam logic signed [17:0] HALF_TURN    = 18'sd32768;
    localparam logic [16:0]        FRAC_FULL    = 17'd65536;
    localparam logic [15:0]        RAD_TURN_HI  = 16'h28BE;
    localparam logic [15:0]        RAD_TURN_LO  = 16'h60DC;

    typedef enum logic [2:0] {
        CFG_X_MIN      = 3'd0,
        CFG_X_MAX      = 3'd1,
        CFG_Y_MIN      = 3'd2,
        CFG_Y_MAX      = 3'd3,
        CFG_INV_LENGTH = 3'd4,
        CFG_STEP_TIME  = 3'd5
    } cfg_idx_t;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_CH   = 6'b000010,
        ST_CS   = 6'b000100,
        ST_DV   = 6'b001000,
        ST_MUL  = 6'b010000,
        ST_FIN  = 6'b100000
    } state_t;

    typedef enum logic [3:0] {
        M_NONE, M_DT, M_A, M_SD, M_B, M_XH, M_XL, M_YH, M_YL, M_C, M_HH, M_HL
    } mul_op_t;

    typedef enum logic [3:0] {
        S_NONE, S_DT, S_A, S_SD, S_B, S_ACC46, S_DX, S_DY, S_C, S_ACC32, S_DH
    } st_op_t;

    typedef struct packed {
        logic       accept;
        logic       cor_init;
        logic       cor_src_steer;
        logic       cor_step;
        logic [3:0] cor_iter;
        logic       save_h;
        logic       div_init;
        logic       div_step;
        logic [4:0] div_bit;
        mul_op_t    mul_op;
        st_op_t     st_op;
        logic       finish;
    } cmd_t;

    function automatic logic [13:0] atan_turn(input logic [3:0] i);
        logic [13:0] v;
        unique case (i)
            4'd0:    v = 14'd8192;
            4'd1:    v = 14'd4836;
            4'd2:    v = 14'd2555;
            4'd3:    v = 14'd1297;
            4'd4:    v = 14'd651;
            4'd5:    v = 14'd326;
            4'd6:    v = 14'd163;
            4'd7:    v = 14'd81;
            4'd8:    v = 14'd41;
            4'd9:    v = 14'd20;
            4'd10:   v = 14'd10;
            4'd11:   v = 14'd5;
            4'd12:   v = 14'd3;
            4'd13:   v = 14'd1;
            default: v = 14'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== sv/kinematic_car_euler_step.sv =====
// Top level of the kinematic car Euler step block.
// Depends on kce_pkg, kce_ctrl and kce_dp.
//
//   channel  | handshake            | payload
//   ---------+----------------------+------------------------------------------------
//   input    | in_valid / in_stall  | command, load_x, load_y, load_heading, speed,
//            |                      | steer, step_fraction
//   output   | out_valid / out_stall| out_x, out_y, out_heading, hit_bound
//   config   | cfg_we               | cfg_index, cfg_data
//
// A step item runs through the accept cycle, 14 CORDIC iterations for the heading, the
// start and 14 iterations of the steering CORDIC, the bit-serial tangent divider, the
// shared multiplier and a finish cycle.
// A load item goes from the accept cycle straight to the finish cycle.
// One item is in work at a time; the next is taken once the previous result sits
// in the output register, which holds it while out_stall is high.
// Reset is asynchronous and clears the pose and restores the register defaults.
`timescale 1ns / 1ps

module kinematic_car_euler_step (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        command,
    input  logic [15:0] load_x,
    input  logic [15:0] load_y,
    input  logic [15:0] load_heading,
    input  logic [15:0] speed,
    input  logic [15:0] steer,
    input  logic [16:0] step_fraction,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] out_x,
    output logic [15:0] out_y,
    output logic [15:0] out_heading,
    output logic        hit_bound,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    kce_pkg::cmd_t cmd;

    kce_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .command   (command),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    kce_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .command       (command),
        .load_x        (load_x),
        .load_y        (load_y),
        .load_heading  (load_heading),
        .speed         (speed),
        .steer         (steer),
        .step_fraction (step_fraction),
        .out_x         (out_x),
        .out_y         (out_y),
        .out_heading   (out_heading),
        .hit_bound     (hit_bound)
    );

endmodule

// ===== sv/kce_ctrl.sv =====
// Sequencer for the kinematic car Euler step block.
// Depends on kce_pkg and kinematic_car_euler_step_assert.svh.
`timescale 1ns / 1ps

module kce_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          command,
    output logic          in_stall,
    output logic          out_valid,
    input  logic          out_stall,
    output kce_pkg::cmd_t cmd
);

    kce_pkg::state_t state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic       out_valid_reg, out_valid_next;
    logic       in_xfer;

    assign in_stall  = (state_reg != kce_pkg::ST_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.mul_op = kce_pkg::M_NONE;
        cmd.st_op  = kce_pkg::S_NONE;
        unique case (state_reg)
            kce_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    cmd.accept = 1'b1;
                    cnt_next   = 5'd0;
                    if (command)
                    begin
                        cmd.cor_init = 1'b1;
                        state_next   = kce_pkg::ST_CH;
                    end
                    else
                    begin
                        state_next = kce_pkg::ST_FIN;
                    end
                end
            end
            kce_pkg::ST_CH:
            begin
                cmd.cor_step = 1'b1;
                cmd.cor_iter = cnt_reg[3:0];
                if (cnt_reg == 5'(kce_pkg::CORDIC_ITERS - 1))
                begin
                    cnt_next   = 5'd0;
                    state_next = kce_pkg::ST_CS;
                end
                else
                begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            kce_pkg::ST_CS:
            begin
                if (cnt_reg == 5'd0)
                begin
                    cmd.save_h        = 1'b1;
                    cmd.cor_init      = 1'b1;
                    cmd.cor_src_steer = 1'b1;
                end
                else
                begin
                    cmd.cor_step = 1'b1;
                    cmd.cor_iter = 4'(cnt_reg - 5'd1);
                end
                if (cnt_reg == 5'(kce_pkg::CORDIC_ITERS))
                begin
                    cnt_next   = 5'd0;
                    state_next = kce_pkg::ST_DV;
                end
                else
                begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            kce_pkg::ST_DV:
            begin
                if (cnt_reg == 5'd0)
                begin
                    cmd.div_init = 1'b1;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                    cmd.div_bit  = 5'(kce_pkg::DIV_BITS) - cnt_reg;
                end
                if (cnt_reg == 5'(kce_pkg::DIV_BITS))
                begin
                    cnt_next   = 5'd0;
                    state_next = kce_pkg::ST_MUL;
                end
                else
                begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            kce_pkg::ST_MUL:
            begin
                unique case (cnt_reg)
                    5'd0:  cmd.mul_op = kce_pkg::M_DT;
                    5'd1:  begin cmd.mul_op = kce_pkg::M_A;  cmd.st_op = kce_pkg::S_DT;    end
                    5'd2:  begin cmd.mul_op = kce_pkg::M_SD; cmd.st_op = kce_pkg::S_A;     end
                    5'd3:  begin cmd.mul_op = kce_pkg::M_B;  cmd.st_op = kce_pkg::S_SD;    end
                    5'd4:  begin cmd.mul_op = kce_pkg::M_XH; cmd.st_op = kce_pkg::S_B;     end
                    5'd5:  begin cmd.mul_op = kce_pkg::M_XL; cmd.st_op = kce_pkg::S_ACC46; end
                    5'd6:  begin cmd.mul_op = kce_pkg::M_YH; cmd.st_op = kce_pkg::S_DX;    end
                    5'd7:  begin cmd.mul_op = kce_pkg::M_YL; cmd.st_op = kce_pkg::S_ACC46; end
                    5'd8:  begin cmd.mul_op = kce_pkg::M_C;  cmd.st_op = kce_pkg::S_DY;    end
                    5'd9:  cmd.st_op = kce_pkg::S_C;
                    5'd10: cmd.mul_op = kce_pkg::M_HH;
                    5'd11: begin cmd.mul_op = kce_pkg::M_HL; cmd.st_op = kce_pkg::S_ACC32; end
                    5'd12: cmd.st_op = kce_pkg::S_DH;
                    default: ;
                endcase
                if (cnt_reg == 5'(kce_pkg::MUL_STEPS - 1))
                begin
                    cnt_next   = 5'd0;
                    state_next = kce_pkg::ST_FIN;
                end
                else
                begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            kce_pkg::ST_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.finish = 1'b1;
                    state_next = kce_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = kce_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = cmd.finish || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kce_pkg::ST_IDLE;
            cnt_reg       <= 5'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

`include "kinematic_car_euler_step_assert.svh"

    `KCE_ASSERT_NXT(a_busy_after_xfer, in_xfer, in_stall, "input taken while busy")
    `KCE_ASSERT_IMP(a_finish_free, cmd.finish, !out_valid_reg || !out_stall, "result overwritten")
    `KCE_ASSERT_IMP(a_ch_count, state_reg == kce_pkg::ST_CH, cnt_reg < 5'd14, "CORDIC count overrun")
    `KCE_ASSERT_IMP(a_mul_count, state_reg == kce_pkg::ST_MUL, cnt_reg <= 5'd12, "multiply overrun")

endmodule

// ===== sv/kce_dp.sv =====
// Datapath for the kinematic car Euler step block: CORDIC, divider, shared multiplier.
// Depends on kce_pkg.
`timescale 1ns / 1ps

module kce_dp (
    input  logic          clk,
    input  logic          rst_n,
    input  kce_pkg::cmd_t cmd,
    input  logic          cfg_we,
    input  logic [2:0]    cfg_index,
    input  logic [15:0]   cfg_data,
    input  logic          command,
    input  logic [15:0]   load_x,
    input  logic [15:0]   load_y,
    input  logic [15:0]   load_heading,
    input  logic [15:0]   speed,
    input  logic [15:0]   steer,
    input  logic [16:0]   step_fraction,
    output logic [15:0]   out_x,
    output logic [15:0]   out_y,
    output logic [15:0]   out_heading,
    output logic          hit_bound
);

    logic signed [15:0] x_min_reg, x_max_reg, y_min_reg, y_max_reg;
    logic [15:0]        inv_length_reg, step_time_reg;

    logic signed [15:0] pos_x_reg, pos_y_reg;
    logic [15:0]        heading_reg;
    logic               hit_reg;

    logic               step_reg;
    logic [15:0]        load_x_reg, load_y_reg, load_h_reg;
    logic signed [15:0] speed_reg, steer_reg;
    logic [16:0]        frac_reg;
    logic signed [15:0] steer_sat;
    logic [16:0]        frac_sat;

    logic signed [32:0] cx_reg, cy_reg, ch_reg, sh_reg;
    logic signed [17:0] cz_reg;
    logic               flip_reg;
    logic signed [15:0] ang16;
    logic signed [17:0] ang, z0;
    logic               f0;
    logic signed [32:0] xs, ys, c_out, s_out, s_abs;
    logic signed [17:0] atan_v;

    logic [49:0]        dv_rem_reg, den_sh;
    logic [31:0]        dv_den_reg;
    logic [17:0]        dv_q_reg;
    logic               dv_neg_reg, dv_ok_reg;
    logic signed [17:0] tn;

    logic signed [35:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [53:0] prod_reg;
    logic signed [71:0] acc_reg, prod_ext, acc_sum;
    logic [15:0]        dt_reg, dh_reg;
    logic signed [33:0] a_reg;
    logic signed [32:0] sd_reg;
    logic signed [35:0] b_reg;
    logic signed [31:0] c_reg;
    logic signed [17:0] dx_reg, dy_reg;

    logic signed [18:0] nx, ny;
    logic signed [15:0] cx_clamp, cy_clamp;
    logic               hit_x, hit_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_min_reg      <= 16'sd0;
            x_max_reg      <= 16'sd4096;
            y_min_reg      <= 16'sd0;
            y_max_reg      <= 16'sd4096;
            inv_length_reg <= 16'd1280;
            step_time_reg  <= 16'd655;
        end
        else if (cfg_we)
        begin
            unique case (kce_pkg::cfg_idx_t'(cfg_index))
                kce_pkg::CFG_X_MIN:      x_min_reg      <= cfg_data;
                kce_pkg::CFG_X_MAX:      x_max_reg      <= cfg_data;
                kce_pkg::CFG_Y_MIN:      y_min_reg      <= cfg_data;
                kce_pkg::CFG_Y_MAX:      y_max_reg      <= cfg_data;
                kce_pkg::CFG_INV_LENGTH: inv_length_reg <= cfg_data;
                kce_pkg::CFG_STEP_TIME:  step_time_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if ($signed(steer) > kce_pkg::STEER_LIMIT)
            steer_sat = kce_pkg::STEER_LIMIT;
        else if ($signed(steer) < -kce_pkg::STEER_LIMIT)
            steer_sat = -kce_pkg::STEER_LIMIT;
        else
            steer_sat = steer;
        frac_sat = (step_fraction > kce_pkg::FRAC_FULL) ? kce_pkg::FRAC_FULL : step_fraction;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            step_reg   <= command;
            load_x_reg <= load_x;
            load_y_reg <= load_y;
            load_h_reg <= load_heading;
            speed_reg  <= speed;
            steer_reg  <= steer_sat;
            frac_reg   <= frac_sat;
        end
    end

    // CORDIC rotation with a half-turn fold for angles beyond a quarter turn.
    always_comb
    begin
        ang16 = cmd.cor_src_steer ? steer_reg : heading_reg;
        ang   = {{2{ang16[15]}}, ang16};
        if (ang > kce_pkg::QUARTER_TURN)
        begin
            z0 = ang - kce_pkg::HALF_TURN;
            f0 = 1'b1;
        end
        else if (ang < -kce_pkg::QUARTER_TURN)
        begin
            z0 = ang + kce_pkg::HALF_TURN;
            f0 = 1'b1;
        end
        else
        begin
            z0 = ang;
            f0 = 1'b0;
        end
        xs     = cx_reg >>> cmd.cor_iter;
        ys     = cy_reg >>> cmd.cor_iter;
        atan_v = {4'b0, kce_pkg::atan_turn(cmd.cor_iter)};
        c_out  = flip_reg ? -cx_reg : cx_reg;
        s_out  = flip_reg ? -cy_reg : cy_reg;
        s_abs  = s_out[32] ? -s_out : s_out;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cor_init)
        begin
            cx_reg   <= kce_pkg::CORDIC_GAIN;
            cy_reg   <= 33'sd0;
            cz_reg   <= z0;
            flip_reg <= f0;
        end
        else if (cmd.cor_step)
        begin
            if (!cz_reg[17])
            begin
                cx_reg <= cx_reg - ys;
                cy_reg <= cy_reg + xs;
                cz_reg <= cz_reg - atan_v;
            end
            else
            begin
                cx_reg <= cx_reg + ys;
                cy_reg <= cy_reg - xs;
                cz_reg <= cz_reg + atan_v;
            end
        end
        if (cmd.save_h)
        begin
            ch_reg <= c_out;
            sh_reg <= s_out;
        end
    end

    // Restoring division for the steering tangent, one quotient bit per cycle.
    assign den_sh = {18'b0, dv_den_reg} << cmd.div_bit;

    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
        begin
            dv_rem_reg <= {1'b0, s_abs, 16'b0};
            dv_den_reg <= c_out[31:0];
            dv_q_reg   <= 18'd0;
            dv_neg_reg <= s_out[32];
            dv_ok_reg  <= !c_out[32] && (c_out != 33'sd0);
        end
        else if (cmd.div_step && (dv_rem_reg >= den_sh))
        begin
            dv_rem_reg              <= dv_rem_reg - den_sh;
            dv_q_reg[cmd.div_bit]   <= 1'b1;
        end
    end

    always_comb
    begin
        if (!dv_ok_reg)
            tn = 18'sd0;
        else if (dv_neg_reg)
            tn = -$signed(dv_q_reg);
        else
            tn = $signed(dv_q_reg);
    end

    // Shared multiplier: one product per cycle, consumed in the next one.
    always_comb
    begin
        unique case (cmd.mul_op)
            kce_pkg::M_DT: begin mul_a = {20'b0, step_time_reg};       mul_b = {1'b0, frac_reg}; end
            kce_pkg::M_A:  begin mul_a = {{20{speed_reg[15]}}, speed_reg}; mul_b = tn; end
            kce_pkg::M_SD: begin mul_a = {{20{speed_reg[15]}}, speed_reg}; mul_b = {2'b0, dt_reg}; end
            kce_pkg::M_B:  begin mul_a = {{2{a_reg[33]}}, a_reg};       mul_b = {2'b0, dt_reg}; end
            kce_pkg::M_XH: begin mul_a = {{3{sd_reg[32]}}, sd_reg};     mul_b = {ch_reg[32], ch_reg[32:16]}; end
            kce_pkg::M_XL: begin mul_a = {{3{sd_reg[32]}}, sd_reg};     mul_b = {2'b0, ch_reg[15:0]}; end
            kce_pkg::M_YH: begin mul_a = {{3{sd_reg[32]}}, sd_reg};     mul_b = {sh_reg[32], sh_reg[32:16]}; end
            kce_pkg::M_YL: begin mul_a = {{3{sd_reg[32]}}, sd_reg};     mul_b = {2'b0, sh_reg[15:0]}; end
            kce_pkg::M_C:  begin mul_a = b_reg;                         mul_b = {2'b0, inv_length_reg}; end
            kce_pkg::M_HH: begin mul_a = {{4{c_reg[31]}}, c_reg};       mul_b = {2'b0, kce_pkg::RAD_TURN_HI}; end
            kce_pkg::M_HL: begin mul_a = {{4{c_reg[31]}}, c_reg};       mul_b = {2'b0, kce_pkg::RAD_TURN_LO}; end
            default:       begin mul_a = 36'sd0;                        mul_b = 18'sd0; end
        endcase
        prod_ext = {{18{prod_reg[53]}}, prod_reg};
        acc_sum  = acc_reg + prod_ext;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        unique case (cmd.st_op)
            kce_pkg::S_DT:    dt_reg  <= prod_reg[31:16];
            kce_pkg::S_A:     a_reg   <= prod_reg[33:0];
            kce_pkg::S_SD:    sd_reg  <= prod_reg[32:0];
            kce_pkg::S_B:     b_reg   <= prod_reg[51:16];
            kce_pkg::S_ACC46: acc_reg <= (prod_ext <<< 16) + (72'sd1 <<< 45);
            kce_pkg::S_DX:    dx_reg  <= acc_sum[63:46];
            kce_pkg::S_DY:    dy_reg  <= acc_sum[63:46];
            kce_pkg::S_C:     c_reg   <= prod_reg[51:20];
            kce_pkg::S_ACC32: acc_reg <= (prod_ext <<< 16) + (72'sd1 <<< 31);
            kce_pkg::S_DH:    dh_reg  <= acc_sum[47:32];
            default: ;
        endcase
    end

    // Upper bound tested first: inverted bounds give max above it, else min.
    always_comb
    begin
        nx = {{3{pos_x_reg[15]}}, pos_x_reg} + {dx_reg[17], dx_reg};
        ny = {{3{pos_y_reg[15]}}, pos_y_reg} + {dy_reg[17], dy_reg};
        if (nx > $signed({{3{x_max_reg[15]}}, x_max_reg}))
        begin
            cx_clamp = x_max_reg;
            hit_x    = 1'b1;
        end
        else if (nx < $signed({{3{x_min_reg[15]}}, x_min_reg}))
        begin
            cx_clamp = x_min_reg;
            hit_x    = 1'b1;
        end
        else
        begin
            cx_clamp = nx[15:0];
            hit_x    = 1'b0;
        end
        if (ny > $signed({{3{y_max_reg[15]}}, y_max_reg}))
        begin
            cy_clamp = y_max_reg;
            hit_y    = 1'b1;
        end
        else if (ny < $signed({{3{y_min_reg[15]}}, y_min_reg}))
        begin
            cy_clamp = y_min_reg;
            hit_y    = 1'b1;
        end
        else
        begin
            cy_clamp = ny[15:0];
            hit_y    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg   <= 16'sd0;
            pos_y_reg   <= 16'sd0;
            heading_reg <= 16'd0;
            hit_reg     <= 1'b0;
        end
        else if (cmd.finish)
        begin
            if (step_reg)
            begin
                pos_x_reg   <= cx_clamp;
                pos_y_reg   <= cy_clamp;
                heading_reg <= heading_reg + dh_reg;
                hit_reg     <= hit_x || hit_y;
            end
            else
            begin
                pos_x_reg   <= load_x_reg;
                pos_y_reg   <= load_y_reg;
                heading_reg <= load_h_reg;
                hit_reg     <= 1'b0;
            end
        end
    end

    assign out_x       = pos_x_reg;
    assign out_y       = pos_y_reg;
    assign out_heading = heading_reg;
    assign hit_bound   = hit_reg;

endmodule

// ===== tb/sv/kinematic_car_euler_step_tb.sv =====
// Self-checking testbench for the kinematic car Euler step block.
// Depends on kce_pkg and kinematic_car_euler_step; predicts each pose in place.
`timescale 1ns / 1ps

module kinematic_car_euler_step_tb;

    typedef struct packed {
        logic [15:0] px;
        logic [15:0] py;
        logic [15:0] hd;
        logic        hit;
    } pose_t;

    localparam int WATCHDOG = 20000;
    localparam int DRAIN    = 80;
    localparam int HOLD_LEN = 400;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        command = 1'b0;
    logic [15:0] load_x = '0, load_y = '0, load_heading = '0;
    logic [15:0] speed = '0, steer = '0;
    logic [16:0] step_fraction = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [15:0] out_x, out_y, out_heading;
    logic        hit_bound;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    logic [15:0] r_xmin = 16'd0, r_xmax = 16'd4096, r_ymin = 16'd0, r_ymax = 16'd4096;
    logic [15:0] r_invl = 16'd1280, r_step = 16'd655;
    logic [15:0] m_px = '0, m_py = '0, m_hd = '0;

    pose_t expected_poses[$];
    int    mismatches = 0;
    int    idle_count = 0;
    int    send_idle_pct = 0;
    int    stall_pct = 0;
    int    hold_cycles = 0;
    bit    hold_off = 1'b0;

    always #5 clk = ~clk;

    kinematic_car_euler_step u_top (.*);

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic void cordic_turn(input longint ang, output longint c,
                                        output longint s);
        longint x, y, z, xs, ys;
        bit     flip;
        int     atab[14];
        atab = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1};
        x = 652032875;
        y = 0;
        z = ang;
        flip = 1'b0;
        if (z > 16384) begin z -= 32768; flip = 1'b1; end
        else if (z < -16384) begin z += 32768; flip = 1'b1; end
        for (int i = 0; i < 14; i++)
        begin
            xs = floor_shift(x, i);
            ys = floor_shift(y, i);
            if (z >= 0)
            begin
                x -= ys; y += xs; z -= atab[i];
            end
            else
            begin
                x += ys; y -= xs; z += atab[i];
            end
        end
        if (flip)
        begin
            x = -x; y = -y;
        end
        c = x;
        s = y;
    endfunction

    function automatic logic [15:0] clamp_axis(longint v, logic [15:0] lo, logic [15:0] hi,
                                               inout bit hit);
        if (v > longint'($signed(hi))) begin hit = 1'b1; return hi; end
        if (v < longint'($signed(lo))) begin hit = 1'b1; return lo; end
        return v[15:0];
    endfunction

    task automatic predict_pose(logic cmd, logic [15:0] lx, logic [15:0] ly,
                                logic [15:0] lh, logic [15:0] spd_in,
                                logic [15:0] str_in, logic [16:0] frac_in);
        longint spd, str, frac, dt, ch, sh, cs, ss, tn, a, b, c, dx, dy, dh;
        bit     hit;
        pose_t  p;
        hit = 1'b0;
        if (cmd == 1'b0)
        begin
            m_px = lx; m_py = ly; m_hd = lh;
        end
        else
        begin
            spd = longint'($signed(spd_in));
            str = longint'($signed(str_in));
            frac = frac_in;
            if (frac > 65536) frac = 65536;
            dt = (longint'(r_step) * frac) >>> 16;
            if (str > 10430) str = 10430;
            if (str < -10430) str = -10430;
            cordic_turn(longint'($signed(m_hd)), ch, sh);
            dx = floor_shift(spd * ch * dt + (64'sd1 <<< 45), 46);
            dy = floor_shift(spd * sh * dt + (64'sd1 <<< 45), 46);
            cordic_turn(str, cs, ss);
            tn = (cs > 0) ? (ss * 65536) / cs : 0;
            a = spd * tn;
            b = floor_shift(a * dt, 16);
            c = floor_shift(b * longint'(r_invl), 20);
            dh = floor_shift(c * 683565276 + (64'sd1 <<< 31), 32);
            m_px = clamp_axis(longint'($signed(m_px)) + dx, r_xmin, r_xmax, hit);
            m_py = clamp_axis(longint'($signed(m_py)) + dy, r_ymin, r_ymax, hit);
            m_hd = m_hd + dh[15:0];
        end
        p.px = m_px; p.py = m_py; p.hd = m_hd; p.hit = hit;
        expected_poses = {expected_poses, p};
    endtask

    // The valid line is left high after a transfer; the next item, an idle gap or a
    // drain replaces it at the following falling edge.
    task automatic send_item(logic cmd, logic [15:0] lx, logic [15:0] ly,
                             logic [15:0] lh, logic [15:0] spd, logic [15:0] str,
                             logic [16:0] frac);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
            while ($urandom_range(99) < send_idle_pct) @(negedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd; load_x <= lx; load_y <= ly; load_heading <= lh;
        speed <= spd; steer <= str; step_fraction <= frac;
        predict_pose(cmd, lx, ly, lh, spd, str, frac);
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_random_step();
        logic [16:0] frac;
        case ($urandom_range(3))
            0: frac = 17'd65536;
            1: frac = 17'h10000 + 17'($urandom_range(65535));
            default: frac = 17'($urandom_range(65536));
        endcase
        send_item(1'b1, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), frac);
    endtask

    task automatic send_random_load();
        send_item(1'b0, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 17'($urandom));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_poses.size() != 0) @(negedge clk);
        repeat (DRAIN) @(negedge clk);
    endtask

    task automatic write_reg(kce_pkg::cfg_idx_t idx, logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            kce_pkg::CFG_X_MIN:      r_xmin = val;
            kce_pkg::CFG_X_MAX:      r_xmax = val;
            kce_pkg::CFG_Y_MIN:      r_ymin = val;
            kce_pkg::CFG_Y_MAX:      r_ymax = val;
            kce_pkg::CFG_INV_LENGTH: r_invl = val;
            kce_pkg::CFG_STEP_TIME:  r_step = val;
            default: ;
        endcase
    endtask

    task automatic write_bounds(logic [15:0] xl, logic [15:0] xh, logic [15:0] yl,
                                logic [15:0] yh);
        wait_drained();
        write_reg(kce_pkg::CFG_X_MIN, xl);
        write_reg(kce_pkg::CFG_X_MAX, xh);
        write_reg(kce_pkg::CFG_Y_MIN, yl);
        write_reg(kce_pkg::CFG_Y_MAX, yh);
    endtask

    task automatic test_directed();
        send_item(1'b0, 16'h0800, 16'h0800, 16'h0000, 16'hFFFF, 16'hFFFF, 17'h1FFFF);
        send_item(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h0000, 17'd65536);
        send_item(1'b1, 16'h0, 16'h0, 16'h0, 16'h8000, 16'h7FFF, 17'd65536);
        send_item(1'b1, 16'h0, 16'h0, 16'h0, 16'h7FFF, 16'h8000, 17'h1FFFF);
        send_item(1'b1, 16'h0, 16'h0, 16'h0, 16'h7FFF, 16'd10430, 17'd0);
        send_item(1'b0, 16'h7FFF, 16'h8000, 16'h4000, 16'h0, 16'h0, 17'h0);
        send_item(1'b1, 16'h0, 16'h0, 16'h0, 16'h1000, 16'd10431, 17'd32768);
        send_item(1'b0, 16'h8000, 16'h7FFF, 16'h8000, 16'h0, 16'h0, 17'h0);
        send_item(1'b1, 16'h0, 16'h0, 16'h0, 16'h7FFF, 16'hD742, 17'd65537);
        send_item(1'b0, 16'h0, 16'h0, 16'h4001, 16'h0, 16'h0, 17'h0);
        send_item(1'b1, 16'h0, 16'h0, 16'h0, 16'h7FFF, 16'h0100, 17'd65536);
        send_item(1'b0, 16'h0, 16'h0, 16'hBFFF, 16'h0, 16'h0, 17'h0);
        send_item(1'b1, 16'h0, 16'h0, 16'h0, 16'h8000, 16'hFF00, 17'd65536);
    endtask

    task automatic test_config_extremes();
        write_bounds(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
        write_reg(kce_pkg::CFG_INV_LENGTH, 16'hFFFF);
        write_reg(kce_pkg::CFG_STEP_TIME, 16'hFFFF);
        repeat (30) send_random_step();
        send_random_load();
        repeat (10) send_random_step();
        write_bounds(16'h1000, 16'hF000, 16'h2000, 16'hE000);
        write_reg(kce_pkg::CFG_INV_LENGTH, 16'd0);
        write_reg(kce_pkg::CFG_STEP_TIME, 16'd1);
        repeat (20) send_random_step();
        wait_drained();
        write_reg(kce_pkg::CFG_STEP_TIME, 16'd0);
        write_reg(kce_pkg::CFG_INV_LENGTH, 16'd1);
        repeat (10) send_random_step();
        wait_drained();
        cfg_we <= 1'b1;
        cfg_index <= 3'd7;
        cfg_data <= 16'hFFFF;
        @(negedge clk);
        cfg_index <= 3'd6;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic test_random_phase(int idle, int stall, int n);
        send_idle_pct = idle;
        stall_pct = stall;
        wait_drained();
        write_reg(kce_pkg::CFG_STEP_TIME, 16'($urandom_range(65535, 1)));
        write_reg(kce_pkg::CFG_INV_LENGTH, 16'($urandom_range(65535, 1)));
        write_bounds(16'($urandom_range(8192)) - 16'd12288, 16'($urandom_range(12288)),
                     16'hE000 - 16'($urandom_range(8192)), 16'($urandom_range(20000)));
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(9) == 0) send_random_load();
            else send_random_step();
        end
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        stall_pct = 0;
        hold_off = 1'b1;
        repeat (6) send_random_step();
        wait_drained();
        send_random_load();
        repeat (4) send_random_step();
    endtask

    always @(negedge clk)
    begin
        if (hold_off)
        begin
            out_stall <= 1'b1;
            hold_cycles++;
            if (hold_cycles >= HOLD_LEN)
            begin
                hold_cycles = 0;
                hold_off = 1'b0;
            end
        end
        else
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        pose_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_poses.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transfer: x=%h y=%h h=%h hit=%b",
                             out_x, out_y, out_heading, hit_bound);
            end
            else
            begin
                e = expected_poses.pop_front();
                if (out_x !== e.px || out_y !== e.py || out_heading !== e.hd ||
                    hit_bound !== e.hit)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp x=%h y=%h h=%h hit=%b ",
                                  "got x=%h y=%h h=%h hit=%b"},
                                 e.px, e.py, e.hd, e.hit, out_x, out_y, out_heading,
                                 hit_bound);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= WATCHDOG)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_config_extremes();
        test_random_phase(0, 0, 240);
        test_random_phase(60, 0, 240);
        test_random_phase(0, 60, 240);
        test_random_phase(19, 19, 240);
        test_backpressure();
        wait_drained();
        if (mismatches == 0 && expected_poses.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+sv
sv/kce_pkg.sv
sv/kce_ctrl.sv
sv/kce_dp.sv
sv/kinematic_car_euler_step.sv
tb/sv/kinematic_car_euler_step_tb.sv
